/* hw/rtl/srpg_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srpg_pkg
// Shared types and constants for the stepper ramp pulse generator.
// ----------------------------------------------------------------------------
package srpg_pkg;

  // Configuration register indexes
  localparam logic [2:0] CfgPeriodFloor   = 3'd0;
  localparam logic [2:0] CfgPeriodCeiling = 3'd1;
  localparam logic [2:0] CfgRampSlope     = 3'd2;
  localparam logic [2:0] CfgRampOffset    = 3'd3;
  localparam logic [2:0] CfgTicksPerMs    = 3'd4;

  localparam int CfgIndexBits = 3;
  localparam int CfgDataBits  = 22;
  localparam int PeriodBits   = 11;

  // Register values after reset
  localparam logic [10:0] RstPeriodFloor   = 11'd600;
  localparam logic [10:0] RstPeriodCeiling = 11'd1600;
  localparam logic [10:0] RstRampSlope     = 11'h670;  // -400
  localparam logic [21:0] RstRampOffset    = 22'd1400000;
  localparam logic [15:0] RstTicksPerMs    = 16'd1000;

  // Period quantizer: trunc(num / 50000) * 50, only below QuotThresh.
  // From QuotThresh up the quantized period exceeds any 11-bit ceiling.
  localparam int QuotThresh = 2050000;
  localparam int NumLoBits  = 21;
  localparam int RecipShift = 40;
  localparam logic [24:0] RecipMult = 25'd21990233;  // ceil(2^40 / 50000)
  localparam int QuotBits   = 6;

  typedef struct packed {
    logic [10:0] period_floor;
    logic [10:0] period_ceiling;
    logic [10:0] ramp_slope;
    logic [21:0] ramp_offset;
    logic [15:0] ticks_per_ms;
  } cfg_t;

  typedef struct packed {
    logic step_level;
    logic direction_cw;
    logic busy_res;
    logic move_done;
    logic move_timed_out;
  } result_t;

endpackage

/* hw/rtl/srpg_period.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srpg_period
// Turns the registered ramp numerator into the next step period:
// quantize to 50 ticks, then clamp to floor, ceiling and one tick.
// ----------------------------------------------------------------------------
module srpg_period
  import srpg_pkg::*;
#(
  parameter int PROD_BITS = 35
) (
  input  logic signed [PROD_BITS-1:0] ramp_num,
  input  logic [10:0]                 period_floor,
  input  logic [10:0]                 period_ceiling,
  output logic [PeriodBits-1:0]       period
);

  localparam logic signed [PROD_BITS-1:0] BigNum = PROD_BITS'(QuotThresh);

  logic                          is_pos;
  logic                          is_big;
  logic [NumLoBits-1:0]          num_lo;
  logic [NumLoBits+24:0]         recip_prod;
  logic [QuotBits-1:0]           quot;
  logic [11:0]                   quant;
  logic [11:0]                   base;
  logic [11:0]                   floored;
  logic [11:0]                   capped;

  // Divide by 50000 through a reciprocal multiply
  assign is_pos     = ramp_num > 0;
  assign is_big     = ramp_num >= BigNum;
  assign num_lo     = ramp_num[NumLoBits-1:0];
  assign recip_prod = (NumLoBits+25)'(num_lo) * (NumLoBits+25)'(RecipMult);
  assign quot       = recip_prod[RecipShift +: QuotBits];

  // quot * 50 = quot * (32 + 16 + 2)
  assign quant = (12'(quot) << 5) + (12'(quot) << 4) + (12'(quot) << 1);

  // Non-positive numerators quantize to zero; huge ones land above any ceiling
  always_comb begin
    if (!is_pos) begin
      base = 12'd0;
    end else if (is_big) begin
      base = 12'hFFF;
    end else begin
      base = quant;
    end
  end

  // Floor first, then ceiling, then at least one tick
  assign floored = (base < {1'b0, period_floor}) ? {1'b0, period_floor} : base;
  assign capped  = (floored > {1'b0, period_ceiling}) ? {1'b0, period_ceiling} : floored;
  assign period  = (capped == 12'd0) ? PeriodBits'(1) : capped[PeriodBits-1:0];

endmodule

/* hw/rtl/srpg_seq.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srpg_seq
// Move state per tick: step/period counters, pulse counter, timeout
// prescaler, and the registered ramp numerator for the next expiry.
// ----------------------------------------------------------------------------
module srpg_seq
  import srpg_pkg::*;
#(
  parameter int STEP_COUNT_BITS = 23,
  parameter int PULSE_TICKS     = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        tick,        // input word accepted this cycle
  input  logic        mode,
  input  logic [22:0] move_ticks,
  input  logic [15:0] budget_ms,
  input  cfg_t        cfg,
  input  cfg_t        cfg_next,
  output result_t     res
);

  localparam int N  = STEP_COUNT_BITS;
  localparam int PW = (N + 12 > 24) ? N + 12 : 24;
  localparam logic [23:0] CountMax = 24'((64'd1 << N) - 64'd1);

  logic [N-1:0]            steps_issued, steps_issued_next;
  logic [N-1:0]            steps_target, steps_target_next;
  logic                    dir_is_cw, dir_is_cw_next;
  logic                    moving, moving_next;
  logic [PeriodBits-1:0]   period_left, period_left_next;
  logic [2:0]              pulse_left, pulse_left_next;
  logic [15:0]             ms_prescale, ms_prescale_next;
  logic [15:0]             ms_remaining, ms_remaining_next;
  logic signed [PW-1:0]    ramp_num, ramp_num_next;
  logic                    done_flag, timeout_flag;

  logic                    neg;
  logic [22:0]             mag;
  logic [N-1:0]            mag_sat;
  logic [PeriodBits-1:0]   period_dec;
  logic [PeriodBits-1:0]   new_period;
  logic [16:0]             prescale_inc;
  logic [N-1:0]            rem_next;
  logic [N-1:0]            near_next;
  logic signed [PW-1:0]    slope_ext, near_ext, offset_ext;

  srpg_period #(
    .PROD_BITS(PW)
  ) u_period (
    .ramp_num      (ramp_num),
    .period_floor  (cfg.period_floor),
    .period_ceiling(cfg.period_ceiling),
    .period        (new_period)
  );

  // Step count magnitude, saturated to the counter width
  assign neg     = move_ticks[22];
  assign mag     = neg ? 23'(~move_ticks + 23'd1) : move_ticks;
  assign mag_sat = ({1'b0, mag} > CountMax) ? '1 : mag[N-1:0];

  assign period_dec   = (period_left != '0) ? period_left - PeriodBits'(1) : period_left;
  assign prescale_inc = {1'b0, ms_prescale} + 17'd1;

  // Per-tick update
  always_comb begin
    steps_issued_next = steps_issued;
    steps_target_next = steps_target;
    dir_is_cw_next    = dir_is_cw;
    moving_next       = moving;
    period_left_next  = period_left;
    pulse_left_next   = pulse_left;
    ms_prescale_next  = ms_prescale;
    ms_remaining_next = ms_remaining;
    done_flag         = 1'b0;
    timeout_flag      = 1'b0;
    if (tick) begin
      if (pulse_left != 3'd0) begin
        pulse_left_next = pulse_left - 3'd1;
      end
      if (mode) begin
        steps_issued_next = '0;
        steps_target_next = mag_sat;
        dir_is_cw_next    = neg || (move_ticks == 23'd0);
        moving_next       = 1'b1;
        period_left_next  = PeriodBits'(1);
        ms_prescale_next  = 16'd0;
        ms_remaining_next = budget_ms;
      end else if (moving) begin
        if (ms_remaining == 16'd0) begin
          moving_next  = 1'b0;
          timeout_flag = 1'b1;
        end else begin
          period_left_next = period_dec;
          if (period_dec == '0) begin
            if (steps_issued == steps_target) begin
              moving_next = 1'b0;
              done_flag   = 1'b1;
            end else begin
              period_left_next  = new_period;
              pulse_left_next   = 3'(PULSE_TICKS);
              steps_issued_next = steps_issued + N'(1);
            end
          end
          // millisecond prescaler
          if (prescale_inc >= {1'b0, cfg.ticks_per_ms}) begin
            ms_prescale_next  = 16'd0;
            ms_remaining_next = ms_remaining - 16'd1;
          end else begin
            ms_prescale_next = prescale_inc[15:0];
          end
        end
      end
    end
  end

  // Ramp numerator for the state after this tick: slope * near + offset
  assign rem_next   = steps_target_next - steps_issued_next;
  assign near_next  = (steps_issued_next < rem_next) ? steps_issued_next : rem_next;
  assign slope_ext  = PW'($signed(cfg_next.ramp_slope));
  assign near_ext   = PW'(near_next);
  assign offset_ext = PW'(cfg_next.ramp_offset);
  assign ramp_num_next = slope_ext * near_ext + offset_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      steps_issued <= '0;
      steps_target <= '0;
      dir_is_cw    <= 1'b0;
      moving       <= 1'b0;
      period_left  <= '0;
      pulse_left   <= 3'd0;
      ms_prescale  <= 16'd0;
      ms_remaining <= 16'd0;
      ramp_num     <= PW'(RstRampOffset);
    end else begin
      steps_issued <= steps_issued_next;
      steps_target <= steps_target_next;
      dir_is_cw    <= dir_is_cw_next;
      moving       <= moving_next;
      period_left  <= period_left_next;
      pulse_left   <= pulse_left_next;
      ms_prescale  <= ms_prescale_next;
      ms_remaining <= ms_remaining_next;
      ramp_num     <= ramp_num_next;
    end
  end

  // Result word for this tick
  assign res.step_level     = (pulse_left_next != 3'd0);
  assign res.direction_cw   = dir_is_cw_next;
  assign res.busy_res       = moving_next;
  assign res.move_done      = done_flag;
  assign res.move_timed_out = timeout_flag;

endmodule

/* hw/rtl/srpg_skid.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srpg_skid
// Output register with one skid entry, so a tick can be taken while the
// previous result word waits on a stalled receiver.
// ----------------------------------------------------------------------------
module srpg_skid
  import srpg_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_res,
  input  logic    out_stall,
  output logic    out_valid,
  output result_t out_res,
  output logic    full
);

  result_t skid_res;
  logic    skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      // output slot free or drained this cycle
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || !out_stall) begin
      if (skid_valid) begin
        out_res <= skid_res;
      end else if (push) begin
        out_res <= push_res;
      end
    end else if (push) begin
      skid_res <= push_res;
    end
  end

  assign full = skid_valid;

endmodule

/* hw/rtl/stepper_ramp_pulse_generator_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stepper_ramp_pulse_generator_core
// Trapezoidal-ramp step pulse generator driven by one word per microsecond.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): each word is one microsecond tick.
//   mode=1 starts a move with move_ticks steps (sign gives direction) and a
//   timeout of budget_ms milliseconds; mode=0 is a plain tick.
//   Output channel (out_valid / out_stall): exactly one result word per
//   tick with step_level, direction_cw, busy_res and the one-tick
//   move_done / move_timed_out flags.
//   A tick's result word is registered at the output or in the skid entry.
//   One tick is taken every cycle while in_stall is low; the period math
//   runs from a ramp numerator registered one tick ahead, so each path
//   holds a single multiply. When the receiver stalls, one more tick lands
//   in a skid entry and then in_stall rises until the output drains.
//   Config writes (cfg_we, cfg_index, cfg_data) are taken at any edge and
//   are meant for idle periods. Reset clears the move, the pulse and the
//   output channel and loads the default ramp settings.
// ----------------------------------------------------------------------------
module stepper_ramp_pulse_generator_core
  import srpg_pkg::*;
#(
  parameter int STEP_COUNT_BITS = 23,
  parameter int PULSE_TICKS     = 4
) (
  input  logic                    clk,
  input  logic                    rst,
  // configuration
  input  logic                    cfg_we,
  input  logic [CfgIndexBits-1:0] cfg_index,
  input  logic [CfgDataBits-1:0]  cfg_data,
  // tick input
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    mode,
  input  logic signed [22:0]      move_ticks,
  input  logic [15:0]             budget_ms,
  // result output
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    step_level,
  output logic                    direction_cw,
  output logic                    busy_res,
  output logic                    move_done,
  output logic                    move_timed_out
);

  cfg_t    cfg, cfg_next;
  result_t tick_res, out_res;
  logic    tick;
  logic    skid_full;

  // Configuration registers
  always_comb begin
    cfg_next = cfg;
    if (cfg_we) begin
      case (cfg_index)
        CfgPeriodFloor:   cfg_next.period_floor   = cfg_data[10:0];
        CfgPeriodCeiling: cfg_next.period_ceiling = cfg_data[10:0];
        CfgRampSlope:     cfg_next.ramp_slope     = cfg_data[10:0];
        CfgRampOffset:    cfg_next.ramp_offset    = cfg_data[21:0];
        CfgTicksPerMs:    cfg_next.ticks_per_ms   = cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.period_floor   <= RstPeriodFloor;
      cfg.period_ceiling <= RstPeriodCeiling;
      cfg.ramp_slope     <= RstRampSlope;
      cfg.ramp_offset    <= RstRampOffset;
      cfg.ticks_per_ms   <= RstTicksPerMs;
    end else begin
      cfg <= cfg_next;
    end
  end

  assign tick     = in_valid && !in_stall;
  assign in_stall = skid_full;

  srpg_seq #(
    .STEP_COUNT_BITS(STEP_COUNT_BITS),
    .PULSE_TICKS    (PULSE_TICKS)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .tick      (tick),
    .mode      (mode),
    .move_ticks(move_ticks),
    .budget_ms (budget_ms),
    .cfg       (cfg),
    .cfg_next  (cfg_next),
    .res       (tick_res)
  );

  srpg_skid u_skid (
    .clk      (clk),
    .rst      (rst),
    .push     (tick),
    .push_res (tick_res),
    .out_stall(out_stall),
    .out_valid(out_valid),
    .out_res  (out_res),
    .full     (skid_full)
  );

  assign step_level     = out_res.step_level;
  assign direction_cw   = out_res.direction_cw;
  assign busy_res       = out_res.busy_res;
  assign move_done      = out_res.move_done;
  assign move_timed_out = out_res.move_timed_out;

`ifndef NO_ASSERTIONS
  // A held skid word implies a word is waiting at the output
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_full |-> out_valid)
    else $error("skid entry held with empty output register");

  // A move cannot both complete and time out on one tick
  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(move_done && move_timed_out))
    else $error("done and timeout flags raised together");

  // Both end flags report a stopped move
  a_end_not_busy: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (move_done || move_timed_out)) |-> !busy_res)
    else $error("end flag raised while still busy");

  // A start tick leaves the block busy with no end flag
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (tick && mode) |-> (tick_res.busy_res && !tick_res.move_done
                        && !tick_res.move_timed_out))
    else $error("start tick did not begin a move");
`endif

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for stepper_ramp_pulse_generator_core.
// Tick words go out through a valid/stall driver with random gaps, and the
// result port is stalled at random. Every result word is checked against a
// tick-accurate software copy of the ramp, step pulse and timeout logic.
// Phases run the reset ramp, the register extremes (zero and maximum
// prescale, floor above ceiling, a ramp that drops below one tick) and
// random ramp settings.
// ----------------------------------------------------------------------------
module tb;
  import srpg_pkg::*;

  localparam logic ModePlain = 1'b0;
  localparam logic ModeStart = 1'b1;
  localparam int PulseLen    = 4;
  localparam int IdleLimit   = 1000;
  localparam int MaxGap      = 12;

  typedef struct packed {
    logic        mode;
    logic [22:0] ticks;
    logic [15:0] tmo;
  } tick_word_t;

  // DUT ports; the inputs are all driven from time zero
  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    cfg_we = 1'b0;
  logic [CfgIndexBits-1:0] cfg_index = '0;
  logic [CfgDataBits-1:0]  cfg_data = '0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic                    mode = 1'b0;
  logic signed [22:0]      move_ticks = '0;
  logic [15:0]             budget_ms = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic                    step_level;
  logic                    direction_cw;
  logic                    busy_res;
  logic                    move_done;
  logic                    move_timed_out;

  stepper_ramp_pulse_generator_core uut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // Ramp settings as the predictor sees them
  logic [10:0]        ramp_floor  = RstPeriodFloor;
  logic [10:0]        ramp_ceil   = RstPeriodCeiling;
  logic signed [10:0] ramp_slope  = RstRampSlope;
  logic [21:0]        ramp_offset = RstRampOffset;
  logic [15:0]        ms_ticks    = RstTicksPerMs;

  // Motion state of the predictor
  logic [22:0] steps_done   = '0;
  logic [22:0] steps_goal   = '0;
  logic        going_cw     = 1'b0;
  logic        in_motion    = 1'b0;
  logic [10:0] period_count = '0;
  logic [2:0]  pulse_count  = '0;
  logic [16:0] prescale     = '0;
  logic [15:0] ms_left      = '0;

  tick_word_t ticks_to_send[$];
  result_t    expected_words[$];

  string field_name [5] = '{"move_timed_out", "move_done", "busy_res",
                            "direction_cw", "step_level"};

  int errors      = 0;
  int n_ticks     = 0;
  int n_checked   = 0;
  int n_starts    = 0;
  int n_finished  = 0;
  int n_timeouts  = 0;
  int idle_cycles = 0;

  // Driver / receiver bookkeeping
  tick_word_t cur_word = '0;
  bit         word_out = 1'b0;
  bit         word_taken = 1'b0;
  bit         gaps_on = 1'b1;
  bit         stalls_on = 1'b1;
  int         gap_left = 0;
  int         hold_left = 0;

  task automatic flag_error(string msg);
    errors++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // Period for the next step, from the distance to the nearer end of the move
  function automatic logic [10:0] ramp_period();
    logic [22:0] rest;
    logic [22:0] closest;
    longint      p;
    rest = (steps_goal >= steps_done) ? steps_goal - steps_done : '0;
    closest = (steps_done < rest) ? steps_done : rest;
    p = longint'(ramp_slope) * longint'(closest) + longint'(ramp_offset);
    p = p / 1000;
    p = (p / 50) * 50;
    if (p < longint'(ramp_floor)) p = longint'(ramp_floor);
    if (p > longint'(ramp_ceil)) p = longint'(ramp_ceil);
    if (p < 1) p = 1;
    return p[10:0];
  endfunction

  // Advance the motion state by one tick and return the result word
  task automatic step_motor_tick(input tick_word_t w, output result_t r);
    logic done_f;
    logic tmo_f;
    done_f = 1'b0;
    tmo_f = 1'b0;
    if (pulse_count != 0) pulse_count--;
    if (w.mode == ModeStart) begin
      // load the move; negative or zero counts run clockwise
      steps_done = '0;
      steps_goal = w.ticks[22] ? (~w.ticks + 23'd1) : w.ticks;
      going_cw = w.ticks[22] || (w.ticks == '0);
      in_motion = 1'b1;
      period_count = 11'd1;
      prescale = '0;
      ms_left = w.tmo;
      n_starts++;
    end else if (in_motion) begin
      if (ms_left == 0) begin
        in_motion = 1'b0;
        tmo_f = 1'b1;
      end else begin
        if (period_count != 0) period_count--;
        if (period_count == 0) begin
          if (steps_done == steps_goal) begin
            in_motion = 1'b0;
            done_f = 1'b1;
          end else begin
            period_count = ramp_period();
            pulse_count = 3'(PulseLen);
            steps_done = steps_done + 23'd1;
          end
        end
        prescale = prescale + 17'd1;
        if (prescale >= {1'b0, ms_ticks}) begin
          prescale = '0;
          ms_left--;
        end
      end
    end
    n_finished += done_f;
    n_timeouts += tmo_f;
    r.step_level     = (pulse_count != 0);
    r.direction_cw   = going_cw;
    r.busy_res       = in_motion;
    r.move_done      = done_f;
    r.move_timed_out = tmo_f;
  endtask

  // Tick driver: one word per handshake, random gap before each word
  always @(negedge clk) begin
    if (word_taken) begin
      word_out = 1'b0;
      word_taken = 1'b0;
      if ($urandom_range(0, 31) == 0) gaps_on = !gaps_on;
      gap_left = gaps_on ? $urandom_range(0, MaxGap) : 0;
    end
    if (!word_out && gap_left > 0) begin
      gap_left--;
    end else if (!word_out && ticks_to_send.size() > 0) begin
      cur_word = ticks_to_send.pop_front();
      word_out = 1'b1;
    end
    in_valid   <= word_out;
    mode       <= cur_word.mode;
    move_ticks <= cur_word.ticks;
    budget_ms  <= cur_word.tmo;
  end

  // Result receiver: stall for a random count after each word
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Input acceptance, result check and watchdog
  always @(posedge clk) begin
    result_t got;
    result_t want;
    result_t guess;
    bit      moved;
    moved = 1'b0;
    if (!rst && in_valid && !in_stall) begin
      step_motor_tick({mode, move_ticks, budget_ms}, guess);
      expected_words.push_back(guess);
      word_taken = 1'b1;
      n_ticks++;
      moved = 1'b1;
    end
    if (!rst && out_valid && !out_stall) begin
      got = {step_level, direction_cw, busy_res, move_done, move_timed_out};
      moved = 1'b1;
      if (expected_words.size() == 0) begin
        flag_error("result word with no tick pending");
      end else begin
        want = expected_words.pop_front();
        for (int i = 0; i < 5; i++) begin
          if (got[i] !== want[i])
            flag_error($sformatf("word %0d %s got %b expected %b",
                                 n_checked, field_name[i], got[i], want[i]));
        end
        n_checked++;
      end
      if ($urandom_range(0, 31) == 0) stalls_on = !stalls_on;
      hold_left = stalls_on ? $urandom_range(0, MaxGap) : 0;
    end
    idle_cycles = moved ? 0 : idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("Timeout: no handshake for %0d cycles", IdleLimit);
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic push_word(logic md, logic [22:0] cnt, logic [15:0] tmo);
    ticks_to_send.push_back('{md, cnt, tmo});
  endtask

  // Plain ticks; the unused fields carry random bits
  task automatic push_plain(int n);
    repeat (n) push_word(ModePlain, 23'($urandom), 16'($urandom));
  endtask

  // Zero-timeout start stops any move, then let the pulse run out
  task automatic push_halt();
    push_word(ModeStart, 23'($urandom), 16'd0);
    push_plain(1 + PulseLen);
  endtask

  // Random moves: mostly a start and a run of ticks, some bare noise ticks
  task automatic push_moves(int budget, int max_run, int max_tmo);
    int          sent;
    int          run;
    int          sel;
    logic [22:0] cnt;
    logic [15:0] tmo;
    sent = 0;
    while (sent < budget) begin
      if ($urandom_range(0, 9) == 0) begin
        run = $urandom_range(1, 6);
        push_plain(run);
        sent += run;
      end else begin
        sel = $urandom_range(0, 9);
        if (sel < 7) cnt = 23'($urandom_range(0, 16) - 8);
        else if (sel < 9) cnt = 23'($urandom);
        else begin
          case ($urandom_range(0, 3))
            0: cnt = 23'h400000;
            1: cnt = 23'h3FFFFF;
            2: cnt = '0;
            default: cnt = '1;
          endcase
        end
        sel = $urandom_range(0, 9);
        if (sel == 0) tmo = '0;
        else if (sel == 1) tmo = 16'($urandom);
        else tmo = 16'($urandom_range(1, max_tmo));
        run = $urandom_range(0, max_run);
        push_word(ModeStart, cnt, tmo);
        push_plain(run);
        sent += run + 1;
      end
    end
    push_halt();
  endtask

  // Wait until every tick has gone out and every result has come back
  task automatic drain();
    while (ticks_to_send.size() != 0 || word_out || expected_words.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(logic [CfgIndexBits-1:0] idx, logic [CfgDataBits-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      CfgPeriodFloor:   ramp_floor  = val[10:0];
      CfgPeriodCeiling: ramp_ceil   = val[10:0];
      CfgRampSlope:     ramp_slope  = val[10:0];
      CfgRampOffset:    ramp_offset = val[21:0];
      CfgTicksPerMs:    ms_ticks    = val[15:0];
      default: ;
    endcase
  endtask

  // Write all five registers, then resume on the next rising edge
  task automatic set_ramp(int floor_v, int ceil_v, int slope_v, int offset_v, int ms_v);
    write_reg(CfgPeriodFloor, 22'(floor_v));
    write_reg(CfgPeriodCeiling, 22'(ceil_v));
    write_reg(CfgRampSlope, 22'(11'(slope_v)));
    write_reg(CfgRampOffset, 22'(offset_v));
    write_reg(CfgTicksPerMs, 22'(ms_v));
    @(negedge clk) cfg_we <= 1'b0;
    repeat (2) @(negedge clk);
    @(posedge clk);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
    @(posedge clk);

    // Reset ramp: idle ticks, zero count, zero timeout, extreme counts,
    // restart while a pulse is high
    push_plain(2);
    push_word(ModeStart, 23'd0, 16'd5);
    push_plain(2);
    push_word(ModeStart, 23'd3, 16'd0);
    push_plain(1);
    push_word(ModeStart, 23'h400000, 16'hFFFF);
    push_plain(2);
    push_word(ModeStart, 23'h3FFFFF, 16'd1);
    push_plain(4);
    push_halt();
    drain();

    // Period pinned to one tick, every tick is a millisecond
    set_ramp(1, 2047, -1000, 0, 1);
    push_word(ModeStart, 23'd5, 16'd20);
    push_plain(12);
    push_moves(55, 40, 30);
    drain();

    // Floor above ceiling, prescaler expiring every tick
    set_ramp(2047, 1, 0, 4000000, 0);
    push_moves(55, 40, 30);
    drain();

    // Ramp that quantizes to 50 at the ends and falls below one mid-move;
    // slowest prescale so only zero timeouts fire
    set_ramp(0, 50, -1000, 51000, 65535);
    push_moves(100, 200, 40);
    drain();

    // Random ramp settings
    repeat (3) begin
      set_ramp($urandom_range(0, 60), $urandom_range(1, 120),
               -int'($urandom_range(0, 1000)), $urandom_range(0, 200000),
               ($urandom_range(0, 5) == 0) ? 65535 : $urandom_range(1, 30));
      push_moves(35, 60, 6);
      drain();
    end

    repeat (8) @(posedge clk);
    $display("Checked %0d result words over %0d moves: %0d finished, %0d timed out",
             n_checked, n_starts, n_finished, n_timeouts);
    $display("Ramp settings: reset values, register extremes and 3 random sets");
    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

/* stepper_ramp_pulse_generator_core.f */
hw/rtl/srpg_pkg.sv
hw/rtl/srpg_period.sv
hw/rtl/srpg_seq.sv
hw/rtl/srpg_skid.sv
hw/rtl/stepper_ramp_pulse_generator_core.sv
tb/tb.sv
